@@ src/hbed_pkg.sv @@
// Shared types and constants for the Huffman build/encode/decode block.
// Used by hbed_front, hbed_back, huffman_build_encode_decode and the testbench; no dependencies.
`timescale 1ns / 1ps
package hbed_pkg;

  localparam int MAX_LEAVES = 256;
  localparam int NODE_SLOTS = 2 * MAX_LEAVES;
  localparam int CODE_BITS  = 64;
  localparam int CODE_CAP   = (CODE_BITS < 63) ? CODE_BITS : 63;
  localparam int NODE_W     = $clog2(NODE_SLOTS);
  localparam int LEAF_AW    = $clog2(MAX_LEAVES);
  localparam int LEN_W      = 6;
  localparam int QDEPTH     = 2;

  // request codes on req_type
  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_ENCODE = 2'd1;
  localparam logic [1:0] REQ_DECODE = 2'd2;

  // result kinds
  localparam logic [1:0] RK_BUILD  = 2'd0;
  localparam logic [1:0] RK_CODE   = 2'd1;
  localparam logic [1:0] RK_SYMBOL = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FEW      = 2'd1;
  localparam logic [1:0] ST_MISSING  = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  typedef enum logic [1:0] {
    K_LOAD,
    K_ENCODE,
    K_DECODE
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  symbol;
    logic [23:0] weight;
    logic        last_leaf;
    logic        code_bit;
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_SCAN,
    S_JOIN_A,
    S_JOIN_B,
    S_JOIN_N,
    S_CODE_START,
    S_CODE_WAIT,
    S_CODE_STEP,
    S_CODE_WRITE,
    S_ENC_CMP,
    S_ENC_OUT,
    S_DEC_CHILD,
    S_DEC_OUT
  } state_e;

endpackage

@@ src/hbed_front.sv @@
// Command front end: accepts requests, classifies them and queues them.
// Depends on hbed_pkg.
`timescale 1ns / 1ps
module hbed_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [1:0]       req_type_i,
  input  logic [7:0]       symbol_i,
  input  logic [23:0]      leaf_weight_i,
  input  logic             last_leaf_i,
  input  logic             code_bit_i,
  output logic             busy_o,
  output logic             cmd_valid_o,
  output hbed_pkg::cmd_t   cmd_o,
  input  logic             cmd_pop_i
);
  import hbed_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  cmd_t            q_mem [QDEPTH];
  logic [PW-1:0]   wr_q, rd_q;
  logic [PW:0]     cnt_q, cnt_d;
  logic            known;
  logic            push;
  cmd_t            cmd_new;

  // classify the request; an unknown code is taken and dropped
  always_comb begin
    known = 1'b1;
    cmd_new.symbol    = symbol_i;
    cmd_new.weight    = leaf_weight_i;
    cmd_new.last_leaf = last_leaf_i;
    cmd_new.code_bit  = code_bit_i;
    case (req_type_i)
      REQ_LOAD:   cmd_new.kind = K_LOAD;
      REQ_ENCODE: cmd_new.kind = K_ENCODE;
      REQ_DECODE: cmd_new.kind = K_DECODE;
      default: begin
        cmd_new.kind = K_LOAD;
        known = 1'b0;
      end
    endcase
  end

  assign busy_o      = (cnt_q == (PW+1)'(QDEPTH));
  assign push        = start_i && !busy_o && known;
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = q_mem[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !cmd_pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && cmd_pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // advance queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (cmd_pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
    end
  end

  // hold queued commands
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_q] <= cmd_new;
    end
  end

endmodule

@@ src/hbed_back.sv @@
// Command back end: node and code tables, tree build sequencer, encode and decode.
// Depends on hbed_pkg; fed by hbed_front.
`timescale 1ns / 1ps
module hbed_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cmd_valid_i,
  input  hbed_pkg::cmd_t          cmd_i,
  output logic                    cmd_pop_o,
  output logic                    result_valid_o,
  output logic [1:0]              result_kind_o,
  output logic [1:0]              status_o,
  output logic [63:0]             code_word_o,
  output logic [5:0]              code_length_o,
  output logic [7:0]              decoded_symbol_o
);
  import hbed_pkg::*;

  // memories
  logic [31:0]         wgt_mem  [NODE_SLOTS];
  logic [NODE_W-1:0]   par_mem  [NODE_SLOTS];
  logic [NODE_W-1:0]   lft_mem  [NODE_SLOTS];
  logic [NODE_W-1:0]   rgt_mem  [NODE_SLOTS];
  logic [7:0]          sym_mem  [MAX_LEAVES];
  logic [CODE_BITS-1:0] cbit_mem [MAX_LEAVES];
  logic [LEN_W-1:0]    clen_mem [MAX_LEAVES];

  logic [31:0]          wgt_rd_q;
  logic [NODE_W-1:0]    par_rd_q, lft_rd_q, rgt_rd_q;
  logic [7:0]           sym_rd_q;
  logic [CODE_BITS-1:0] cbit_rd_q;
  logic [LEN_W-1:0]     clen_rd_q;

  logic [NODE_W-1:0]    node_ra, par_wa, nd_wa, par_wd, lft_wd, rgt_wd;
  logic                 par_we, nd_we, wgt_we;
  logic [31:0]          wgt_wd;
  logic [LEAF_AW-1:0]   leaf_ra, sym_wa, code_wa;
  logic                 sym_we, code_we;

  // control state
  state_e               state_q, state_d;
  cmd_t                 cmd_q, cmd_d;
  logic [NODE_W:0]      leaf_cnt_q, leaf_cnt_d;
  logic                 built_q, built_d, closed_q, closed_d, ovf_q, ovf_d;
  logic [NODE_W-1:0]    dec_q, dec_d;

  // build and code walk registers
  logic [NODE_W-1:0]    i_q, i_d, iss_q, iss_d, cmp_idx_q, cmp_idx_d;
  logic                 cmp_vld_q, cmp_vld_d;
  logic [NODE_W-1:0]    best_q, best_d, sec_q, sec_d;
  logic [31:0]          bw_q, bw_d, sw_q, sw_d;
  logic [NODE_W-1:0]    m_q, m_d, p_q, p_d, l_q, l_d;
  logic [LEN_W-1:0]     k_q, k_d;
  logic [CODE_BITS-1:0] bits_q, bits_d;
  logic [LEAF_AW-1:0]   idx_q, idx_d;

  // result register
  logic                 res_vld_q, res_vld_d;
  logic [1:0]           res_kind_q, res_kind_d, res_st_q, res_st_d;
  logic [63:0]          res_word_q, res_word_d;
  logic [5:0]           res_len_q, res_len_d;
  logic [7:0]           res_sym_q, res_sym_d;

  // helpers
  logic [NODE_W:0]      cnt_base, cnt_new;
  logic [NODE_W-1:0]    root, child;
  logic [NODE_W:0]      root_w;

  assign root_w = {leaf_cnt_q[NODE_W-1:0], 1'b0} - 1'b1;
  assign root   = root_w[NODE_W-1:0];
  assign cnt_base = closed_q ? '0 : leaf_cnt_q;
  assign cnt_new  = cnt_base + 1'b1;
  assign child    = cmd_q.code_bit ? rgt_rd_q : lft_rd_q;

  // next state and datapath control
  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    leaf_cnt_d = leaf_cnt_q;
    built_d    = built_q;
    closed_d   = closed_q;
    ovf_d      = ovf_q;
    dec_d      = dec_q;
    i_d        = i_q;
    iss_d      = iss_q;
    cmp_idx_d  = cmp_idx_q;
    cmp_vld_d  = 1'b0;
    best_d     = best_q;
    sec_d      = sec_q;
    bw_d       = bw_q;
    sw_d       = sw_q;
    m_d        = m_q;
    p_d        = p_q;
    l_d        = l_q;
    k_d        = k_q;
    bits_d     = bits_q;
    idx_d      = idx_q;
    res_vld_d  = 1'b0;
    res_kind_d = res_kind_q;
    res_st_d   = res_st_q;
    res_word_d = res_word_q;
    res_len_d  = res_len_q;
    res_sym_d  = res_sym_q;
    cmd_pop_o  = 1'b0;
    node_ra    = '0;
    leaf_ra    = '0;
    par_we     = 1'b0;
    par_wa     = '0;
    par_wd     = '0;
    nd_we      = 1'b0;
    wgt_we     = 1'b0;
    nd_wa      = '0;
    lft_wd     = '0;
    rgt_wd     = '0;
    wgt_wd     = '0;
    sym_we     = 1'b0;
    sym_wa     = '0;
    code_we    = 1'b0;
    code_wa    = '0;

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          case (cmd_i.kind)
            K_LOAD: state_d = S_LOAD;
            K_ENCODE: begin
              if (built_q) begin
                leaf_ra = '0;
                idx_d   = '0;
                state_d = S_ENC_CMP;
              end else begin
                res_vld_d  = 1'b1;
                res_kind_d = RK_CODE;
                res_st_d   = ST_MISSING;
                res_word_d = '0;
                res_len_d  = '0;
                res_sym_d  = '0;
              end
            end
            K_DECODE: begin
              if (built_q && dec_q != '0) begin
                node_ra = dec_q;
                state_d = S_DEC_CHILD;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end

      S_LOAD: begin
        state_d = S_IDLE;
        if (closed_q) begin
          built_d  = 1'b0;
          dec_d    = '0;
          closed_d = 1'b0;
        end
        leaf_cnt_d = cnt_base;
        ovf_d      = closed_q ? 1'b0 : ovf_q;
        if (cnt_base < (NODE_W+1)'(MAX_LEAVES)) begin
          leaf_cnt_d = cnt_new;
          sym_we = 1'b1;
          sym_wa = cnt_base[LEAF_AW-1:0];
          nd_wa  = cnt_new[NODE_W-1:0];
          wgt_we = 1'b1;
          wgt_wd = {8'd0, cmd_q.weight};
          par_we = 1'b1;
          par_wa = cnt_new[NODE_W-1:0];
          par_wd = '0;
        end else begin
          ovf_d = 1'b1;
        end
        if (cmd_q.last_leaf) begin
          closed_d = 1'b1;
          if (ovf_d) begin
            res_vld_d  = 1'b1;
            res_st_d   = ST_OVERFLOW;
          end else if (leaf_cnt_d < (NODE_W+1)'(2)) begin
            res_vld_d  = 1'b1;
            res_st_d   = ST_FEW;
          end else begin
            i_d     = leaf_cnt_d[NODE_W-1:0] + 1'b1;
            iss_d   = NODE_W'(1);
            best_d  = '0;
            sec_d   = '0;
            state_d = S_SCAN;
          end
          res_kind_d = RK_BUILD;
          res_word_d = '0;
          res_len_d  = '0;
          res_sym_d  = '0;
        end
      end

      // find the two lightest parentless nodes below i
      S_SCAN: begin
        if (iss_q < i_q) begin
          node_ra   = iss_q;
          iss_d     = iss_q + 1'b1;
          cmp_vld_d = 1'b1;
          cmp_idx_d = iss_q;
        end
        if (cmp_vld_q) begin
          if (par_rd_q == '0) begin
            if (best_q == '0 || wgt_rd_q < bw_q) begin
              sec_d  = best_q;
              sw_d   = bw_q;
              best_d = cmp_idx_q;
              bw_d   = wgt_rd_q;
            end else if (sec_q == '0 || wgt_rd_q < sw_q) begin
              sec_d = cmp_idx_q;
              sw_d  = wgt_rd_q;
            end
          end
        end else if (iss_q >= i_q) begin
          state_d = S_JOIN_A;
        end
      end

      S_JOIN_A: begin
        par_we  = 1'b1;
        par_wa  = best_q;
        par_wd  = i_q;
        nd_we   = 1'b1;
        wgt_we  = 1'b1;
        nd_wa   = i_q;
        lft_wd  = best_q;
        rgt_wd  = sec_q;
        wgt_wd  = bw_q + sw_q;
        state_d = S_JOIN_B;
      end

      S_JOIN_B: begin
        par_we  = 1'b1;
        par_wa  = sec_q;
        par_wd  = i_q;
        state_d = S_JOIN_N;
      end

      S_JOIN_N: begin
        par_we = 1'b1;
        par_wa = i_q;
        par_wd = '0;
        if (i_q == root) begin
          l_d     = NODE_W'(1);
          state_d = S_CODE_START;
        end else begin
          i_d     = i_q + 1'b1;
          iss_d   = NODE_W'(1);
          best_d  = '0;
          sec_d   = '0;
          state_d = S_SCAN;
        end
      end

      // walk from leaf l up to the root
      S_CODE_START: begin
        node_ra = l_q;
        m_d     = l_q;
        k_d     = '0;
        bits_d  = '0;
        state_d = S_CODE_WAIT;
      end

      S_CODE_WAIT: begin
        if (par_rd_q == '0) begin
          state_d = S_CODE_WRITE;
        end else begin
          node_ra = par_rd_q;
          p_d     = par_rd_q;
          state_d = S_CODE_STEP;
        end
      end

      S_CODE_STEP: begin
        if (k_q < LEN_W'(CODE_CAP)) begin
          if (rgt_rd_q == m_q) begin
            bits_d[k_q] = 1'b1;
          end
          k_d = k_q + 1'b1;
        end
        m_d = p_q;
        if (par_rd_q == '0) begin
          state_d = S_CODE_WRITE;
        end else begin
          node_ra = par_rd_q;
          p_d     = par_rd_q;
        end
      end

      S_CODE_WRITE: begin
        code_we = 1'b1;
        code_wa = LEAF_AW'(l_q - 1'b1);
        if ({1'b0, l_q} == leaf_cnt_q) begin
          built_d    = 1'b1;
          dec_d      = root;
          res_vld_d  = 1'b1;
          res_kind_d = RK_BUILD;
          res_st_d   = ST_OK;
          res_word_d = '0;
          res_len_d  = '0;
          res_sym_d  = '0;
          state_d    = S_IDLE;
        end else begin
          l_d     = l_q + 1'b1;
          state_d = S_CODE_START;
        end
      end

      // search leaves in index order for the symbol
      S_ENC_CMP: begin
        if (sym_rd_q == cmd_q.symbol) begin
          leaf_ra = idx_q;
          state_d = S_ENC_OUT;
        end else if ({1'b0, idx_q} == leaf_cnt_q[NODE_W-1:0] - 1'b1) begin
          res_vld_d  = 1'b1;
          res_kind_d = RK_CODE;
          res_st_d   = ST_MISSING;
          res_word_d = '0;
          res_len_d  = '0;
          res_sym_d  = '0;
          state_d    = S_IDLE;
        end else begin
          idx_d   = idx_q + 1'b1;
          leaf_ra = idx_q + 1'b1;
        end
      end

      S_ENC_OUT: begin
        res_vld_d  = 1'b1;
        res_kind_d = RK_CODE;
        res_st_d   = ST_OK;
        res_word_d = 64'(cbit_rd_q);
        res_len_d  = clen_rd_q;
        res_sym_d  = '0;
        state_d    = S_IDLE;
      end

      // step one level down; a leaf emits its symbol
      S_DEC_CHILD: begin
        if (child != '0 && {1'b0, child} <= leaf_cnt_q) begin
          leaf_ra = LEAF_AW'(child - 1'b1);
          dec_d   = root;
          state_d = S_DEC_OUT;
        end else begin
          dec_d   = child;
          state_d = S_IDLE;
        end
      end

      S_DEC_OUT: begin
        res_vld_d  = 1'b1;
        res_kind_d = RK_SYMBOL;
        res_st_d   = ST_OK;
        res_word_d = '0;
        res_len_d  = '0;
        res_sym_d  = sym_rd_q;
        state_d    = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      leaf_cnt_q <= '0;
      built_q    <= 1'b0;
      closed_q   <= 1'b0;
      ovf_q      <= 1'b0;
      dec_q      <= '0;
      cmp_vld_q  <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      leaf_cnt_q <= leaf_cnt_d;
      built_q    <= built_d;
      closed_q   <= closed_d;
      ovf_q      <= ovf_d;
      dec_q      <= dec_d;
      cmp_vld_q  <= cmp_vld_d;
      res_vld_q  <= res_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    i_q        <= i_d;
    iss_q      <= iss_d;
    cmp_idx_q  <= cmp_idx_d;
    best_q     <= best_d;
    sec_q      <= sec_d;
    bw_q       <= bw_d;
    sw_q       <= sw_d;
    m_q        <= m_d;
    p_q        <= p_d;
    l_q        <= l_d;
    k_q        <= k_d;
    bits_q     <= bits_d;
    idx_q      <= idx_d;
    res_kind_q <= res_kind_d;
    res_st_q   <= res_st_d;
    res_word_q <= res_word_d;
    res_len_q  <= res_len_d;
    res_sym_q  <= res_sym_d;
  end

  // node tables
  always_ff @(posedge clk_i) begin
    if (par_we) begin
      par_mem[par_wa] <= par_wd;
    end
    if (nd_we) begin
      lft_mem[nd_wa] <= lft_wd;
      rgt_mem[nd_wa] <= rgt_wd;
    end
    if (wgt_we) begin
      wgt_mem[nd_wa] <= wgt_wd;
    end
    par_rd_q <= par_mem[node_ra];
    lft_rd_q <= lft_mem[node_ra];
    rgt_rd_q <= rgt_mem[node_ra];
    wgt_rd_q <= wgt_mem[node_ra];
  end

  // leaf symbol and code tables
  always_ff @(posedge clk_i) begin
    if (sym_we) begin
      sym_mem[sym_wa] <= cmd_q.symbol;
    end
    if (code_we) begin
      cbit_mem[code_wa] <= bits_q;
      clen_mem[code_wa] <= k_q;
    end
    sym_rd_q  <= sym_mem[leaf_ra];
    cbit_rd_q <= cbit_mem[leaf_ra];
    clen_rd_q <= clen_mem[leaf_ra];
  end

  assign result_valid_o   = res_vld_q;
  assign result_kind_o    = res_kind_q;
  assign status_o         = res_st_q;
  assign code_word_o      = res_word_q;
  assign code_length_o    = res_len_q;
  assign decoded_symbol_o = res_sym_q;

  a_leaf_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    leaf_cnt_q <= (NODE_W+1)'(MAX_LEAVES))
    else $error("leaf count beyond table size");

  a_built_needs_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    built_q |-> leaf_cnt_q >= (NODE_W+1)'(2))
    else $error("tree marked built with fewer than two leaves");

  a_join_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_JOIN_A) |-> (best_q != '0 && sec_q != '0 && best_q != sec_q))
    else $error("join without two distinct free nodes");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> (state_q == S_IDLE && cmd_valid_i))
    else $error("command popped outside idle");

endmodule

@@ src/huffman_build_encode_decode.sv @@
// Top level of the Huffman build/encode/decode block.
// Depends on hbed_pkg, hbed_front and hbed_back.
`timescale 1ns / 1ps
// A request is taken when start_i is high and busy_o is low; a two-entry queue lets
// requests arrive while the executor works. Each result shows on the result ports
// for one cycle with result_valid_o and cannot be held off. The executor runs one
// request at a time and is bound by its node and leaf tables, each with one read
// port: a leaf load writes one leaf, a decode bit steps one level down the tree, an
// encode scans the leaves in index order up to the match, or all n when the symbol
// is absent. The item that ends a set of n leaves (2 to 256) builds the tree: each
// of the n-1 joins rescans nodes 1..i-1 for node i, and the code walk then climbs
// from each leaf to the root.
module huffman_build_encode_decode (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  symbol_i,
  input  logic [23:0] leaf_weight_i,
  input  logic        last_leaf_i,
  input  logic        code_bit_i,
  output logic        result_valid_o,
  output logic [1:0]  result_kind_o,
  output logic [1:0]  status_o,
  output logic [63:0] code_word_o,
  output logic [5:0]  code_length_o,
  output logic [7:0]  decoded_symbol_o
);
  import hbed_pkg::*;

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  // accept and queue requests
  hbed_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .req_type_i    (req_type_i),
    .symbol_i      (symbol_i),
    .leaf_weight_i (leaf_weight_i),
    .last_leaf_i   (last_leaf_i),
    .code_bit_i    (code_bit_i),
    .busy_o        (busy_o),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  // execute requests against the tables
  hbed_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_valid_i      (cmd_valid),
    .cmd_i            (cmd),
    .cmd_pop_o        (cmd_pop),
    .result_valid_o   (result_valid_o),
    .result_kind_o    (result_kind_o),
    .status_o         (status_o),
    .code_word_o      (code_word_o),
    .code_length_o    (code_length_o),
    .decoded_symbol_o (decoded_symbol_o)
  );

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for huffman_build_encode_decode: leaf loads, tree builds,
// encode lookups and decode walks, checked against an in-bench tree predictor.
// Depends on hbed_pkg and the block's RTL.
`timescale 1ns / 1ps
module testbench;
  import hbed_pkg::*;

  localparam int LIMIT_CYCLES = 3000000;
  localparam int TARGET_ITEMS = 1500;
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  typedef struct {
    logic [1:0]  kind;
    logic [1:0]  st;
    logic [63:0] word;
    logic [5:0]  len;
    logic [7:0]  sym;
  } hres_t;

  // Tree predictor plus queue of pending results
  class huff_scoreboard;
    logic [31:0] weight_q [NODE_SLOTS];
    logic [7:0]  leaf_sym [MAX_LEAVES + 1];
    logic [8:0]  parent_q [NODE_SLOTS];
    logic [8:0]  left_q   [NODE_SLOTS];
    logic [8:0]  right_q  [NODE_SLOTS];
    logic [63:0] code_bits [MAX_LEAVES + 1];
    logic [5:0]  code_len  [MAX_LEAVES + 1];
    int          n_leaves;
    bit          built;
    logic [8:0]  walk_node;
    bit          closed;
    bit          ovf;
    hres_t       pending[$];
    int          errors;
    int          n_builds, n_codes, n_syms;

    function void clear_links();
      for (int i = 0; i < NODE_SLOTS; i++) begin
        parent_q[i] = '0;
        left_q[i] = '0;
        right_q[i] = '0;
      end
    endfunction

    function int lightest(int last, int skip);
      int best;
      best = 0;
      for (int i = 1; i <= last; i++) begin
        if (parent_q[i] != 0 || i == skip) continue;
        if (best == 0 || weight_q[i] < weight_q[best]) best = i;
      end
      return best;
    endfunction

    // Join nodes, then walk each leaf up to the root for its code
    function void grow_tree(int n);
      int a, b, m, p, k, guard;
      logic [63:0] bits;
      for (int i = n + 1; i <= 2 * n - 1; i++) begin
        a = lightest(i - 1, 0);
        b = lightest(i - 1, a);
        parent_q[a] = i[8:0];
        parent_q[b] = i[8:0];
        left_q[i] = a[8:0];
        right_q[i] = b[8:0];
        weight_q[i] = weight_q[a] + weight_q[b];
      end
      for (int i = 1; i <= n; i++) begin
        m = i;
        p = parent_q[i];
        k = 0;
        guard = 0;
        bits = '0;
        while (p != 0 && guard < NODE_SLOTS) begin
          if (k < CODE_CAP) begin
            if (right_q[p] == m) bits[k] = 1'b1;
            k++;
          end
          m = p;
          p = parent_q[m];
          guard++;
        end
        code_bits[i] = bits;
        code_len[i] = k[5:0];
      end
      built = 1;
      walk_node = 9'(2 * n - 1);
    endfunction

    function new();
      clear_links();
      n_leaves = 0;
      built = 0;
      walk_node = '0;
      closed = 0;
      ovf = 0;
      errors = 0;
      n_builds = 0;
      n_codes = 0;
      n_syms = 0;
    endfunction

    function void push(logic [1:0] kind, logic [1:0] st, logic [63:0] word,
                       logic [5:0] len, logic [7:0] sym);
      hres_t r;
      r.kind = kind;
      r.st = st;
      r.word = word;
      r.len = len;
      r.sym = sym;
      pending.push_back(r);
    endfunction

    // Note one accepted transfer and queue the result it causes
    function void note(logic [1:0] req, logic [7:0] sym, logic [23:0] wt,
                       logic last, logic cbit);
      logic [8:0] child;
      bit hit;
      if (req == REQ_LOAD) begin
        if (closed) begin
          clear_links();
          n_leaves = 0;
          built = 0;
          walk_node = '0;
          ovf = 0;
          closed = 0;
        end
        if (n_leaves < MAX_LEAVES) begin
          n_leaves++;
          leaf_sym[n_leaves] = sym;
          weight_q[n_leaves] = {8'd0, wt};
        end else begin
          ovf = 1;
        end
        if (last) begin
          closed = 1;
          n_builds++;
          if (ovf) push(RK_BUILD, ST_OVERFLOW, '0, '0, '0);
          else if (n_leaves < 2) push(RK_BUILD, ST_FEW, '0, '0, '0);
          else begin
            grow_tree(n_leaves);
            push(RK_BUILD, ST_OK, '0, '0, '0);
          end
        end
      end else if (req == REQ_ENCODE) begin
        hit = 0;
        n_codes++;
        if (built) begin
          for (int i = 1; i <= n_leaves && !hit; i++) begin
            if (leaf_sym[i] == sym) begin
              push(RK_CODE, ST_OK, code_bits[i], code_len[i], '0);
              hit = 1;
            end
          end
        end
        if (!hit) push(RK_CODE, ST_MISSING, '0, '0, '0);
      end else if (req == REQ_DECODE) begin
        if (built && walk_node != 0) begin
          child = cbit ? right_q[walk_node] : left_q[walk_node];
          if (child >= 1 && child <= n_leaves) begin
            push(RK_SYMBOL, ST_OK, '0, '0, leaf_sym[child]);
            walk_node = 9'(2 * n_leaves - 1);
            n_syms++;
          end else begin
            walk_node = child;
          end
        end
      end
    endfunction

    function void field_cmp(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s mismatch: expected %h, got %h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    // Compare one strobed result with the oldest pending one
    function void check(logic [1:0] kind, logic [1:0] st, logic [63:0] word,
                        logic [5:0] len, logic [7:0] sym);
      hres_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result: expected none, got kind %0d status %0d",
                 $time, kind, st);
        errors++;
        return;
      end
      e = pending.pop_front();
      field_cmp("result_kind", 64'(e.kind), 64'(kind));
      field_cmp("status", 64'(e.st), 64'(st));
      field_cmp("code_word", e.word, word);
      field_cmp("code_length", 64'(e.len), 64'(len));
      field_cmp("decoded_symbol", 64'(e.sym), 64'(sym));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [1:0]  req_type_i = '0;
  logic [7:0]  symbol_i = '0;
  logic [23:0] leaf_weight_i = '0;
  logic        last_leaf_i = 1'b0;
  logic        code_bit_i = 1'b0;
  logic        result_valid_o;
  logic [1:0]  result_kind_o;
  logic [1:0]  status_o;
  logic [63:0] code_word_o;
  logic [5:0]  code_length_o;
  logic [7:0]  decoded_symbol_o;

  huff_scoreboard sb = new();
  int cycles = 0;
  int sent = 0;
  int burst_left = 0;
  logic [7:0] set_syms[$];

  always #2 clk_i = ~clk_i;

  huffman_build_encode_decode dut (.*);

  // Check strobed results and guard the run length
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && result_valid_o)
      sb.check(result_kind_o, status_o, code_word_o, code_length_o, decoded_symbol_o);
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Drive one request; hold start within bursts, drop it during gaps
  task automatic send(logic [1:0] req, logic [7:0] sym, logic [23:0] wt,
                      logic last, logic cbit);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 7));
      if (gap > 0) begin
        start_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = int'($urandom_range(1, 24));
    end
    start_i <= 1'b1;
    req_type_i <= req;
    symbol_i <= sym;
    leaf_weight_i <= wt;
    last_leaf_i <= last;
    code_bit_i <= cbit;
    do @(posedge clk_i); while (busy_o);
    sb.note(req, sym, wt, last, cbit);
    burst_left--;
    sent++;
  endtask

  task automatic load(logic [7:0] sym, logic [23:0] wt, logic last);
    send(REQ_LOAD, sym, wt, last, 1'($urandom_range(0, 1)));
  endtask

  task automatic encode(logic [7:0] sym);
    send(REQ_ENCODE, sym, 24'($urandom), 1'($urandom_range(0, 1)),
         1'($urandom_range(0, 1)));
  endtask

  task automatic decode(logic cbit);
    send(REQ_DECODE, 8'($urandom), 24'($urandom), 1'($urandom_range(0, 1)), cbit);
  endtask

  function automatic logic [23:0] pick_weight();
    int r;
    r = int'($urandom_range(0, 19));
    if (r == 0) return '0;
    if (r < 6) return 24'($urandom);
    return 24'($urandom_range(1, 40));
  endfunction

  // Load a set of leaves; mode 1 gives a skewed, deep tree
  task automatic load_set(int n, int mode);
    logic [23:0] wa, wb, wc;
    logic [7:0] s;
    set_syms.delete();
    wa = 24'd1;
    wb = 24'd1;
    for (int i = 0; i < n; i++) begin
      s = (n >= 200) ? 8'(i) : 8'($urandom);
      set_syms.push_back(s);
      if (mode == 1) begin
        load(s, wa, i == n - 1);
        wc = wa + wb;
        wa = wb;
        wb = wc;
      end else if (n >= 200) begin
        load(s, 24'($urandom_range(1, 4)), i == n - 1);
      end else begin
        load(s, pick_weight(), i == n - 1);
      end
    end
  endtask

  initial begin
    int n, mode;
    // Hold reset, then release
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: requests with no tree, too-few set, extreme leaves, zero weight
    encode(8'd0);
    decode(1'b0);
    send(REQ_UNKNOWN, 8'hFF, 24'hFFFFFF, 1'b1, 1'b1);
    load(8'd42, 24'd9, 1'b1);
    encode(8'd42);
    decode(1'b1);
    load(8'd0, 24'd1, 1'b0);
    load(8'd255, 24'hFFFFFF, 1'b1);
    encode(8'd0);
    encode(8'd255);
    encode(8'd77);
    decode(1'b0);
    decode(1'b1);
    load(8'd5, 24'd0, 1'b0);
    load(8'd5, 24'd7, 1'b0);
    load(8'd9, 24'd3, 1'b1);
    encode(8'd5);
    encode(8'd9);
    for (int i = 0; i < 6; i++) decode(i[0]);

    // Random: mostly small sets, one full set, one overflowing set, some deep trees
    for (int round = 0; sent < TARGET_ITEMS; round++) begin
      if (round == 5) n = MAX_LEAVES;
      else if (round == 9) n = MAX_LEAVES + 1;
      else if ($urandom_range(0, 9) == 0) n = 1;
      else n = int'($urandom_range(2, 12));
      mode = ($urandom_range(0, 7) == 0 && n < 200) ? 1 : 0;
      if (mode == 1) n = int'($urandom_range(20, 34));
      load_set(n, mode);
      repeat ($urandom_range(2, 12)) begin
        if ($urandom_range(0, 9) < 8 && set_syms.size() > 0)
          encode(set_syms[$urandom_range(0, set_syms.size() - 1)]);
        else
          encode(8'($urandom));
      end
      repeat ($urandom_range(5, 40)) begin
        if ($urandom_range(0, 19) == 0)
          send(REQ_UNKNOWN, 8'($urandom), 24'($urandom), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)));
        else
          decode(1'($urandom_range(0, 1)));
      end
    end

    // Drain and watch for stray results
    start_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    $display("Covered %0d requests: %0d tree builds, %0d encodes, %0d decoded symbols.",
             sent, sb.n_builds, sb.n_codes, sb.n_syms);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
